FILE: rtl/sssc_pkg.sv
package sssc_pkg;

    // Operation codes carried by an input item
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_MASK  = 2'd1;
    localparam logic [1:0] OP_DOT   = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_COMMON_CATHODE  = 2'd0;
    localparam logic [1:0] CFG_DIGIT_COUNT     = 2'd1;
    localparam logic [1:0] CFG_DIGIT_PERIOD_US = 2'd2;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    // Reset values of the configuration registers
    localparam logic        RST_COMMON_CATHODE  = 1'b1;
    localparam logic [3:0]  RST_DIGIT_COUNT     = 4'd4;
    localparam logic [15:0] RST_DIGIT_PERIOD_US = 16'd4166;

    localparam logic [31:0] US_PER_MS = 32'd1000;
    localparam logic [7:0]  CLEAR_CC  = 8'h00;
    localparam logic [7:0]  CLEAR_CA  = 8'hFF;
    localparam int unsigned DOT_BIT   = 7;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [2:0]  digit_index;
        logic [7:0]  mask_value;
        logic        dot_value;
        logic [31:0] now_ms;
    } sssc_in_t;

    typedef struct packed {
        logic       status;
        logic       advanced;
        logic       all_off;
        logic [2:0] active_digit;
        logic       digit_level;
        logic [7:0] segments_out;
    } sssc_out_t;

endpackage

FILE: rtl/seven_segment_scan_controller.sv
// Pipeline: two register stages (input register, then result register); an accepted item
// moves on to the result register once that is free or being taken, and is held there.
// Throughput: one item per cycle while m_ready stays high; the tick path is one subtract,
// a multiply by the constant 1000 and a 32-bit compare between the two registers.
// Reset: synchronous, active low on aresetn; clears segment and dot buffers, scan pointer,
// last scan time and shown digit, sets the blank flag, loads configuration defaults.
module seven_segment_scan_controller #(
    parameter int unsigned MAX_DIGITS = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input item channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  sssc_pkg::sssc_in_t                  s_data,
    // result item channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output sssc_pkg::sssc_out_t                 m_data,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sssc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sssc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import sssc_pkg::*;

    // Pointer into the digit buffers, and a width that holds any count up to MAX_DIGITS
    // as well as the 4-bit digit_count register.
    localparam int unsigned PTR_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int unsigned CMP_W = (CNT_W > 4) ? CNT_W : 4;
    localparam logic [CMP_W-1:0] MAX_CNT = CMP_W'(MAX_DIGITS);

    // ---------------------------------------------------------------
    // Configuration registers; always ready, writes land in the next cycle
    // ---------------------------------------------------------------
    logic        common_cathode_reg;
    logic [3:0]  digit_count_reg;
    logic [15:0] digit_period_us_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            common_cathode_reg  <= RST_COMMON_CATHODE;
            digit_count_reg     <= RST_DIGIT_COUNT;
            digit_period_us_reg <= RST_DIGIT_PERIOD_US;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_COMMON_CATHODE:  common_cathode_reg  <= cfg_data[0];
                CFG_DIGIT_COUNT:     digit_count_reg     <= cfg_data[3:0];
                CFG_DIGIT_PERIOD_US: digit_period_us_reg <= cfg_data;
                default: ;  // unused index: write is dropped
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Input register stage
    // ---------------------------------------------------------------
    logic       in_valid_reg;
    sssc_in_t   in_item_reg;
    logic       out_valid_reg;
    sssc_out_t  out_item_reg;
    logic       fire;   // item in the input register is processed this cycle

    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_data;
        end
    end

    // ---------------------------------------------------------------
    // Display state
    // ---------------------------------------------------------------
    logic [7:0]       seg_store_reg [MAX_DIGITS];
    logic             dot_store_reg [MAX_DIGITS];
    logic [PTR_W-1:0] scan_ptr_reg, scan_ptr_next;
    logic [31:0]      last_scan_ms_reg, last_scan_ms_next;
    logic [PTR_W-1:0] shown_digit_reg, shown_digit_next;
    logic [7:0]       shown_seg_reg, shown_seg_next;
    logic             blank_reg, blank_next;

    // Effective count: zero acts as one, anything above MAX_DIGITS is clamped.
    logic [CMP_W-1:0] eff_count;
    always_comb begin
        if (digit_count_reg == 4'd0) begin
            eff_count = CMP_W'(1);
        end else if (CMP_W'(digit_count_reg) > MAX_CNT) begin
            eff_count = MAX_CNT;
        end else begin
            eff_count = CMP_W'(digit_count_reg);
        end
    end

    logic [7:0]       clear_val;
    logic [31:0]      gap_us;
    logic             tick_due;
    logic [PTR_W-1:0] scan_digit;   // digit shown by an advancing tick
    logic [CMP_W-1:0] scan_digit_inc;
    logic [7:0]       scan_pattern;
    logic             dot_high;
    logic             idx_bad;
    logic [PTR_W-1:0] wr_idx;
    logic             is_tick, is_mask, is_dot, is_clear;
    logic             do_advance, do_mask_wr, do_dot_wr;

    assign clear_val = common_cathode_reg ? CLEAR_CC : CLEAR_CA;
    assign is_tick   = (in_item_reg.opcode == OP_TICK);
    assign is_mask   = (in_item_reg.opcode == OP_MASK);
    assign is_dot    = (in_item_reg.opcode == OP_DOT);
    assign is_clear  = (in_item_reg.opcode == OP_CLEAR);

    // Elapsed time in us, wrapped to 32 bits, against the per-digit period
    assign gap_us   = (in_item_reg.now_ms - last_scan_ms_reg) * US_PER_MS;
    assign tick_due = (gap_us >= {16'd0, digit_period_us_reg});

    // Stale pointer (count lowered since) restarts the scan at digit 0
    assign scan_digit     = (CMP_W'(scan_ptr_reg) < eff_count) ? scan_ptr_reg : '0;
    assign scan_digit_inc = CMP_W'(scan_digit) + CMP_W'(1);
    assign dot_high       = (dot_store_reg[scan_digit] == common_cathode_reg);
    always_comb begin
        scan_pattern          = seg_store_reg[scan_digit];
        scan_pattern[DOT_BIT] = dot_high;
    end

    assign idx_bad = (CMP_W'(in_item_reg.digit_index) >= eff_count);
    assign wr_idx  = PTR_W'(in_item_reg.digit_index);

    assign do_advance = fire && is_tick && tick_due;
    assign do_mask_wr = fire && is_mask && !idx_bad;
    assign do_dot_wr  = fire && is_dot && !idx_bad;

    always_comb begin
        scan_ptr_next     = scan_ptr_reg;
        last_scan_ms_next = last_scan_ms_reg;
        shown_digit_next  = shown_digit_reg;
        shown_seg_next    = shown_seg_reg;
        blank_next        = blank_reg;
        if (do_advance) begin
            scan_ptr_next     = (scan_digit_inc == eff_count) ? '0 : PTR_W'(scan_digit_inc);
            last_scan_ms_next = in_item_reg.now_ms;
            shown_digit_next  = scan_digit;
            shown_seg_next    = scan_pattern;
            blank_next        = 1'b0;
        end else if (fire && is_clear) begin
            shown_seg_next = clear_val;
            blank_next     = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_ptr_reg     <= '0;
            last_scan_ms_reg <= '0;
            shown_digit_reg  <= '0;
            shown_seg_reg    <= '0;
            blank_reg        <= 1'b1;
        end else begin
            scan_ptr_reg     <= scan_ptr_next;
            last_scan_ms_reg <= last_scan_ms_next;
            shown_digit_reg  <= shown_digit_next;
            shown_seg_reg    <= shown_seg_next;
            blank_reg        <= blank_next;
        end
    end

    // Digit buffers: one write per item, or a full clear
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_DIGITS; i++) begin
                seg_store_reg[i] <= '0;
                dot_store_reg[i] <= 1'b0;
            end
        end else if (fire && is_clear) begin
            for (int i = 0; i < MAX_DIGITS; i++) begin
                seg_store_reg[i] <= clear_val;
                dot_store_reg[i] <= 1'b0;
            end
        end else begin
            if (do_mask_wr) begin
                seg_store_reg[wr_idx] <= in_item_reg.mask_value;
            end
            if (do_dot_wr) begin
                dot_store_reg[wr_idx] <= in_item_reg.dot_value;
            end
        end
    end

    // ---------------------------------------------------------------
    // Result register: state as it stands after the item
    // ---------------------------------------------------------------
    sssc_out_t out_item_next;
    always_comb begin
        out_item_next.status       = (is_mask || is_dot) && idx_bad;
        out_item_next.advanced     = is_tick && tick_due;
        out_item_next.all_off      = blank_next;
        out_item_next.active_digit = 3'(shown_digit_next);
        out_item_next.digit_level  = blank_next ? common_cathode_reg : !common_cathode_reg;
        out_item_next.segments_out = shown_seg_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_item_reg <= out_item_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // An advancing tick always lights a digit
    a_adv_lit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.advanced |-> !m_data.all_off)
        else $error("advanced item reports display blank");

    // A rejected write never advances the scan
    a_status_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status |-> !m_data.advanced)
        else $error("error status together with advance");

    // Scan pointer always addresses an existing buffer entry
    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(scan_ptr_reg) < MAX_DIGITS)
        else $error("scan pointer beyond buffer depth");

    // Display state only moves when an item is processed
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(scan_ptr_reg) && $stable(blank_reg) && $stable(shown_seg_reg))
        else $error("display state changed without an item");

endmodule

FILE: tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sssc_pkg::*;

    localparam int unsigned DIGITS      = 8;
    // generous bound on any single wait for results to drain
    localparam int unsigned DRAIN_LIMIT = 20000;

    // ------------------------------------------------------------------
    // Clock, reset and block ports; every input is known from time zero
    // ------------------------------------------------------------------
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    sssc_in_t    s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    sssc_out_t   m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    always #2 aclk = ~aclk;

    seven_segment_scan_controller #(
        .MAX_DIGITS(DIGITS)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Display model: our own copy of the configuration and the scan state.
    // Updated once per accepted item, in acceptance order.
    // ------------------------------------------------------------------
    logic        cathode;
    logic [3:0]  dig_count;
    logic [15:0] period_us;
    logic [7:0]  seg_buf [DIGITS];
    logic        dot_buf [DIGITS];
    int unsigned scan_ptr;
    logic [31:0] last_ms;
    logic [2:0]  shown_dig;
    logic [7:0]  shown_seg;
    logic        blank;

    sssc_out_t   pending_results [$];   // predicted result items, oldest first
    int unsigned fail_count    = 0;
    int unsigned send_idle_pct = 9;     // first setting: sender idles lightly
    int unsigned recv_idle_pct = 64;    // ... and receiver heavily
    int unsigned hold_cycles   = 0;     // long receiver hold-off, counted below
    logic [31:0] gen_now       = '0;    // running time for well-formed tick runs

    task automatic reset_display_model();
        cathode   = RST_COMMON_CATHODE;
        dig_count = RST_DIGIT_COUNT;
        period_us = RST_DIGIT_PERIOD_US;
        for (int i = 0; i < DIGITS; i++) begin
            seg_buf[i] = '0;
            dot_buf[i] = 1'b0;
        end
        scan_ptr  = 0;
        last_ms   = '0;
        shown_dig = '0;
        shown_seg = '0;
        blank     = 1'b1;
    endtask

    // count of zero behaves as one, anything past the buffer depth as the depth
    function automatic int unsigned live_count();
        if (dig_count == 0)
            return 1;
        if (dig_count > DIGITS)
            return DIGITS;
        return 32'(dig_count);
    endfunction

    function automatic sssc_out_t predict_display(input sssc_in_t it);
        sssc_out_t   r;
        logic [31:0] gap_us;
        int unsigned cnt;
        int unsigned d;
        logic [7:0]  pattern;
        logic [7:0]  clr;
        r   = '0;
        cnt = live_count();
        clr = cathode ? CLEAR_CC : CLEAR_CA;
        case (it.opcode)
            OP_TICK: begin
                // product wraps at 32 bits, as the hardware does
                gap_us = (it.now_ms - last_ms) * US_PER_MS;
                if (gap_us >= {16'd0, period_us}) begin
                    // a pointer left beyond a lowered count restarts at digit 0
                    d       = (scan_ptr < cnt) ? scan_ptr : 0;
                    pattern = seg_buf[d];
                    pattern[DOT_BIT] = (dot_buf[d] == cathode);
                    shown_seg  = pattern;
                    shown_dig  = d[2:0];
                    blank      = 1'b0;
                    scan_ptr   = (d + 1) % cnt;
                    last_ms    = it.now_ms;
                    r.advanced = 1'b1;
                end
            end
            OP_MASK, OP_DOT: begin
                if (it.digit_index >= cnt)
                    r.status = 1'b1;
                else if (it.opcode == OP_MASK)
                    seg_buf[it.digit_index] = it.mask_value;
                else
                    dot_buf[it.digit_index] = it.dot_value;
            end
            default: begin
                // clear: pointer and last scan time are kept
                for (int i = 0; i < DIGITS; i++) begin
                    seg_buf[i] = clr;
                    dot_buf[i] = 1'b0;
                end
                shown_seg = clr;
                blank     = 1'b1;
            end
        endcase
        r.all_off      = blank;
        r.active_digit = shown_dig;
        r.digit_level  = blank ? cathode : ~cathode;
        r.segments_out = shown_seg;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Failure log: first ten printed, the rest only counted
    // ------------------------------------------------------------------
    function automatic void log_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t ERROR: %s", $realtime, msg);
    endfunction

    // ------------------------------------------------------------------
    // Monitor: checks each result item against the oldest prediction and
    // predicts each accepted input item. Sampled at the rising edge only.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        sssc_out_t want;
        sssc_out_t got;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = m_data;
                if (pending_results.size() == 0) begin
                    log_failure($sformatf("result item with none pending: seg=%02h dig=%0d",
                                          got.segments_out, got.active_digit));
                end else begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status || got.advanced !== want.advanced ||
                        got.all_off !== want.all_off ||
                        got.active_digit !== want.active_digit ||
                        got.digit_level !== want.digit_level ||
                        got.segments_out !== want.segments_out)
                        log_failure($sformatf({"mismatch exp st=%0d adv=%0d off=%0d dig=%0d ",
                                               "lvl=%0d seg=%02h, got st=%0d adv=%0d off=%0d ",
                                               "dig=%0d lvl=%0d seg=%02h"},
                                              want.status, want.advanced, want.all_off,
                                              want.active_digit, want.digit_level,
                                              want.segments_out, got.status, got.advanced,
                                              got.all_off, got.active_digit, got.digit_level,
                                              got.segments_out));
                end
            end
            if (s_valid && s_ready)
                pending_results.push_back(predict_display(s_data));
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random back-pressure at the falling edge. A long hold-off
    // requested by a test is counted down here, cycle by cycle.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_ready <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic sssc_in_t make_item(input logic [1:0] op, input logic [2:0] idx,
                                           input logic [7:0] mask, input logic dot,
                                           input logic [31:0] now);
        sssc_in_t it;
        it.opcode      = op;
        it.digit_index = idx;
        it.mask_value  = mask;
        it.dot_value   = dot;
        it.now_ms      = now;
        return it;
    endfunction

    // Mostly well-formed scans: ticks stepping forward by up to about one digit
    // period, writes to digits in range. Some ticks jump to a random time,
    // some writes miss the digit range, and clears are rare.
    function automatic sssc_in_t random_item();
        sssc_in_t    it;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        it   = make_item(OP_TICK, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)), $urandom());
        if (pick < 45) begin
            gen_now   = gen_now + $urandom_range(0, period_us / 1000 + 2);
            it.now_ms = gen_now;
        end else if (pick >= 52) begin
            if (pick < 74)
                it.opcode = OP_MASK;
            else if (pick < 96)
                it.opcode = OP_DOT;
            else
                it.opcode = OP_CLEAR;
            if ($urandom_range(0, 99) < 85)
                it.digit_index = 3'($urandom_range(0, live_count() - 1));
        end
        return it;
    endfunction

    // One item: optional idle cycles, then valid held until accepted.
    // Returns just after the accepting rising edge.
    task automatic send_item(input sssc_in_t it);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    task automatic send_tick(input logic [31:0] now);
        gen_now = now;
        send_item(make_item(OP_TICK, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)), now));
    endtask

    task automatic send_mask(input logic [2:0] idx, input logic [7:0] mask);
        send_item(make_item(OP_MASK, idx, mask, 1'($urandom_range(0, 1)), $urandom()));
    endtask

    task automatic send_dot(input logic [2:0] idx, input logic dot);
        send_item(make_item(OP_DOT, idx, 8'($urandom_range(0, 255)), dot, $urandom()));
    endtask

    task automatic send_clear();
        send_item(make_item(OP_CLEAR, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)), $urandom()));
    endtask

    // Sender drops valid and pauses until every predicted item has come back,
    // then waits on so that the input and result registers are empty.
    task automatic drain_results();
        int unsigned guard;
        guard = 0;
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        repeat (4) @(posedge aclk);
    endtask

    // Register write, only ever with the block idle
    task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
        drain_results();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        case (idx)
            CFG_COMMON_CATHODE:  cathode   = val[0];
            CFG_DIGIT_COUNT:     dig_count = val[3:0];
            CFG_DIGIT_PERIOD_US: period_us = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every operation from reset defaults: writes in and out of range,
    // scan wrap, time wrap, clear on both polarities.
    task automatic test_directed_ops();
        send_tick(32'd0);                 // no time elapsed, stays blank
        send_mask(3'd0, 8'hFF);
        send_mask(3'd3, 8'h5A);
        send_mask(3'd4, 8'h11);           // beyond count of four
        send_mask(3'd7, 8'h00);
        send_dot(3'd0, 1'b1);
        send_dot(3'd1, 1'b1);
        send_dot(3'd7, 1'b1);             // beyond count
        send_tick(32'd4);                 // 4000 us, just short of the period
        send_tick(32'd5);
        send_tick(32'd10);
        send_tick(32'd15);
        send_tick(32'd20);
        send_tick(32'd25);                // scan wraps back to digit 0
        send_tick(32'hFFFF_FFFF);         // huge elapsed after 32-bit wrap
        send_clear();
        send_tick(32'hFFFF_FFFF);         // same time, display stays off
        send_tick(32'd0);
        write_cfg(CFG_COMMON_CATHODE, 16'd0);
        send_clear();                     // common anode clears to all ones
        send_mask(3'd2, 8'h00);
        send_dot(3'd2, 1'b1);
        send_tick(32'd100);
        send_tick(32'd200);
        write_cfg(CFG_COMMON_CATHODE, 16'd1);
    endtask

    // Count and period at and past their limits, including a pointer left
    // behind when the count is lowered.
    task automatic test_count_and_period_limits();
        int unsigned steps;
        write_cfg(CFG_DIGIT_PERIOD_US, 16'd0);    // every tick advances
        write_cfg(CFG_DIGIT_COUNT, 16'd8);
        send_mask(3'd7, 8'hC3);
        send_dot(3'd7, 1'b1);
        drain_results();
        steps = (13 - scan_ptr) % 8;              // park the pointer at digit 5
        repeat (steps) send_tick(32'h0000_1234);
        write_cfg(CFG_DIGIT_COUNT, 16'd3);
        send_tick(32'h0000_1234);                 // stale pointer shows digit 0
        send_mask(3'd5, 8'h3C);
        write_cfg(CFG_DIGIT_COUNT, 16'd0);        // acts as a single digit
        send_mask(3'd0, 8'h7E);
        send_mask(3'd1, 8'h01);
        send_tick(32'h0000_2000);
        send_tick(32'h0000_2000);
        write_cfg(CFG_DIGIT_COUNT, 16'd15);       // clamps to the buffer depth
        send_mask(3'd7, 8'h81);
        send_tick(32'h0000_3000);
        write_cfg(CFG_DIGIT_PERIOD_US, 16'hFFFF);
        send_tick(32'd1000);
        send_tick(32'd1065);                      // 65000 us, not enough
        send_tick(32'd1066);
        write_cfg(CFG_DIGIT_COUNT, 16'(RST_DIGIT_COUNT));
        write_cfg(CFG_DIGIT_PERIOD_US, RST_DIGIT_PERIOD_US);
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering
    // items back to back, so the pipeline fills and input ready drops.
    task automatic test_stall_fill();
        write_cfg(CFG_COMMON_CATHODE, 16'd0);
        write_cfg(CFG_DIGIT_COUNT, 16'd1);
        write_cfg(CFG_DIGIT_PERIOD_US, 16'd1);
        send_idle_pct = 0;
        send_item(random_item());
        hold_cycles = 300;
        repeat (40) send_item(random_item());
        drain_results();
    endtask

    // A phase of random traffic under a fresh random configuration
    task automatic test_random_traffic(input int unsigned n_items,
                                       input int unsigned s_pct, input int unsigned r_pct);
        int unsigned sel;
        logic [15:0] val;
        write_cfg(CFG_COMMON_CATHODE, 16'($urandom_range(0, 1)));
        sel = $urandom_range(0, 4);
        case (sel)
            0:       val = 16'd0;
            1:       val = 16'd1;
            2:       val = 16'd8;
            3:       val = 16'd15;
            default: val = 16'($urandom_range(2, 7));
        endcase
        write_cfg(CFG_DIGIT_COUNT, val);
        sel = $urandom_range(0, 4);
        case (sel)
            0:       val = 16'd0;
            1:       val = 16'd1;
            2:       val = 16'hFFFF;
            3:       val = RST_DIGIT_PERIOD_US;
            default: val = 16'($urandom_range(1000, 20000));
        endcase
        write_cfg(CFG_DIGIT_PERIOD_US, val);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (n_items) send_item(random_item());
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        reset_display_model();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_ops();
        test_count_and_period_limits();
        test_random_traffic(150, 9, 64);
        test_stall_fill();
        test_random_traffic(150, 64, 9);
        test_random_traffic(150, 0, 0);

        drain_results();
        if (pending_results.size() != 0)
            log_failure($sformatf("%0d result items never arrived", pending_results.size()));
        if (fail_count == 0)
            $display("seven_segment_scan_controller verification clean");
        else
            $display("seven_segment_scan_controller verification failed");
        $finish;
    end

    // Hang guard, far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("seven_segment_scan_controller verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/sssc_pkg.sv
rtl/seven_segment_scan_controller.sv
tb/tb_top.sv
